>>> sv/i2cste_pkg.sv
// ----------------------------------------------------------------------------
// i2cste_pkg : shared types and constants
// Codes, widths and the result word layout for the I2C slave transfer engine.
// ----------------------------------------------------------------------------
package i2cste_pkg;

   localparam int TX_DEPTH  = 32;
   localparam int RX_MAX    = 32;
   localparam int TX_IDX_W  = $clog2(TX_DEPTH);
   localparam int POS_W     = 6;
   localparam int LEN_W     = 6;
   localparam int IDX_W     = 5;
   localparam int CMP_W     = 9;

   localparam logic [CMP_W-1:0] TX_DEPTH_C = CMP_W'(TX_DEPTH);
   localparam logic [CMP_W-1:0] RX_MAX_C   = CMP_W'(RX_MAX);

   typedef enum logic [1:0] {
      ACT_LOAD, ACT_ARM_TX, ACT_ARM_RX, ACT_EVENT
   } action_type;

   typedef enum logic [1:0] {
      MODE_READY, MODE_INIT, MODE_TX, MODE_RX
   } mode_type;

   typedef enum logic [1:0] {
      ERR_OK, ERR_RXING, ERR_BUS, ERR_REFUSED
   } err_type;

   typedef enum logic [1:0] {
      CTRL_NONE, CTRL_ENABLE, CTRL_ACK, CTRL_RELEASE
   } ctrl_type;

   // TWI slave status codes
   localparam logic [7:0] ST_ST_SLA_ACK    = 8'hA8;
   localparam logic [7:0] ST_ST_DATA_ACK   = 8'hB8;
   localparam logic [7:0] ST_ST_DATA_NAK   = 8'hC0;
   localparam logic [7:0] ST_ST_LAST_ACK   = 8'hC8;
   localparam logic [7:0] ST_SR_SLA_ACK    = 8'h60;
   localparam logic [7:0] ST_SR_GC_ACK     = 8'h70;
   localparam logic [7:0] ST_SR_DATA_ACK   = 8'h80;
   localparam logic [7:0] ST_SR_GC_DATA_ACK = 8'h90;
   localparam logic [7:0] ST_SR_DATA_NAK   = 8'h88;
   localparam logic [7:0] ST_SR_GC_DATA_NAK = 8'h98;
   localparam logic [7:0] ST_SR_STOP       = 8'hA0;
   localparam logic [7:0] ST_BUS_ERROR     = 8'h00;
   localparam logic [7:0] ST_ARB_SLA_W     = 8'h68;
   localparam logic [7:0] ST_ARB_GC        = 8'h78;
   localparam logic [7:0] ST_ARB_SLA_R     = 8'hB0;

   typedef struct packed {
      logic                  en;
      logic [TX_IDX_W-1:0]   addr;
      logic [7:0]            data;
   } tx_wr_type;

   typedef struct packed {
      logic [POS_W-1:0]  rx_count;
      logic [7:0]        rx_byte;
      logic [IDX_W-1:0]  rx_index;
      logic              rx_valid;
      logic [7:0]        tx_byte;
      logic              tx_valid;
      ctrl_type          bus_ctrl;
      logic [7:0]        error_status;
      err_type           error_kind;
      mode_type          mode;
      logic              success;
      logic              ready_res;
   } rsp_type;

endpackage

>>> sv/i2cste_tx_store.sv
// ----------------------------------------------------------------------------
// i2cste_tx_store : transmit byte store
// One write port; keeps a registered copy of the entry at the next send position.
// ----------------------------------------------------------------------------
module i2cste_tx_store (
   input  logic                          clock,
   input  i2cste_pkg::tx_wr_type         wr,
   input  logic [i2cste_pkg::POS_W-1:0]  next_pos,
   output logic [7:0]                    head_byte
);
   import i2cste_pkg::*;

   logic [7:0] mem [TX_DEPTH];
   logic [7:0] head_ff;
   logic [TX_IDX_W-1:0] rd_addr;

   assign rd_addr   = next_pos[TX_IDX_W-1:0];
   assign head_byte = head_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // write to the entry being fetched is forwarded
   always_ff @(posedge clock) begin
      if ({{(CMP_W-POS_W){1'b0}}, next_pos} < TX_DEPTH_C) begin
         if (wr.en && wr.addr == rd_addr) begin
            head_ff <= wr.data;
         end else begin
            head_ff <= mem[rd_addr];
         end
      end
   end

endmodule

>>> sv/i2cste_rsp_buf.sv
// ----------------------------------------------------------------------------
// i2cste_rsp_buf : result output register with skid stage
// Keeps the input side ready from a register while results back up.
// ----------------------------------------------------------------------------
module i2cste_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  i2cste_pkg::rsp_type  push_data,
   output logic                 can_push,
   output logic                 out_valid,
   input  logic                 out_ready,
   output i2cste_pkg::rsp_type  out_data
);
   import i2cste_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   assign can_push  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

>>> sv/i2c_slave_transfer_engine.sv
// ----------------------------------------------------------------------------
// i2c_slave_transfer_engine : I2C slave transfer engine
// Host loads/arms and bus status events step the slave transfer state; one
// result word per request word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | content
//  req_    | in  | req_tvalid/req_tready  | tuser action, tdata event/load fields
//  rsp_    | out | rsp_tvalid/rsp_tready  | tdata result word (mode, ctrl, bytes)
//
//  One word accepted per cycle while req_tready is high; its result is
//  registered in the output register, or in the skid stage while the output stalls.
//  The transmit store fetch is a registered read of the next send position.
//  A skid stage behind the output register holds one extra result, so
//  req_tready is a register and only drops after two results stall.
//  Synchronous reset clears mode, error state, positions and lengths; store is left.
// ----------------------------------------------------------------------------
module i2c_slave_transfer_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // buf_index[4:0] data_byte[12:5] length[18:13]
                                   // status_code[26:19], zero fill above
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // ready_res[0] success[1] mode[3:2]
                                   // error_kind[5:4] error_status[13:6]
                                   // bus_ctrl[15:14] tx_valid[16] tx_byte[24:17]
                                   // rx_valid[25] rx_index[30:26] rx_byte[38:31]
                                   // rx_count[44:39], zero fill above
);
   import i2cste_pkg::*;

   // request fields
   action_type        act;
   logic [IDX_W-1:0]  buf_index;
   logic [7:0]        data_byte;
   logic [LEN_W-1:0]  len;
   logic [7:0]        status_code;
   logic              accept;

   assign act         = action_type'(req_tuser);
   assign buf_index   = req_tdata[4:0];
   assign data_byte   = req_tdata[12:5];
   assign len         = req_tdata[18:13];
   assign status_code = req_tdata[26:19];

   // engine state
   mode_type         mode_ff, mode_in;
   err_type          err_ff, err_in;
   logic [7:0]       err_st_ff, err_st_in;
   logic [POS_W-1:0] tx_pos_ff, tx_pos_in;
   logic [POS_W-1:0] tx_len_ff, tx_len_in;
   logic [POS_W-1:0] rx_pos_ff, rx_pos_in;
   logic [POS_W-1:0] rx_lim_ff, rx_lim_in;

   tx_wr_type  tx_wr;
   logic [7:0] head_byte;
   rsp_type    rsp;
   rsp_type    rsp_out;
   logic       can_push;
   logic       tx_in_range;
   logic       rx_in_range;
   logic       len_over;

   assign req_tready = can_push;
   assign accept     = req_tvalid && can_push;

   assign tx_in_range = {{(CMP_W-POS_W){1'b0}}, tx_pos_ff} < TX_DEPTH_C;
   assign rx_in_range = (rx_pos_ff < rx_lim_ff) &&
                        ({{(CMP_W-POS_W){1'b0}}, rx_pos_ff} < RX_MAX_C);
   assign len_over    = (act == ACT_ARM_TX) ?
                        ({{(CMP_W-LEN_W){1'b0}}, len} > TX_DEPTH_C) :
                        ({{(CMP_W-LEN_W){1'b0}}, len} > RX_MAX_C);

   // loads write the store whatever the mode
   always_comb begin
      tx_wr.en   = accept && act == ACT_LOAD &&
                   ({{(CMP_W-IDX_W){1'b0}}, buf_index} < TX_DEPTH_C);
      tx_wr.addr = TX_IDX_W'(buf_index);
      tx_wr.data = data_byte;
   end

   i2cste_tx_store u_tx_store (
      .clock     (clock),
      .wr        (tx_wr),
      .next_pos  (tx_pos_in),
      .head_byte (head_byte)
   );

   // next state and result for the word on the input
   always_comb begin
      mode_in   = mode_ff;
      err_in    = err_ff;
      err_st_in = err_st_ff;
      tx_pos_in = tx_pos_ff;
      tx_len_in = tx_len_ff;
      rx_pos_in = rx_pos_ff;
      rx_lim_in = rx_lim_ff;

      rsp          = '0;
      rsp.bus_ctrl = CTRL_NONE;

      if (accept) begin
         unique case (act)
            ACT_LOAD: begin
            end
            ACT_ARM_TX, ACT_ARM_RX: begin
               if (mode_ff != MODE_READY || len_over) begin
                  err_in    = ERR_REFUSED;
                  err_st_in = 8'd0;
               end else begin
                  mode_in = MODE_INIT;
                  if (act == ACT_ARM_TX) begin
                     tx_len_in = len;
                     tx_pos_in = '0;
                  end else begin
                     rx_lim_in = len;
                     rx_pos_in = '0;
                  end
                  rsp.bus_ctrl = CTRL_ACK;
               end
            end
            ACT_EVENT: begin
               unique case (status_code)
                  ST_ST_SLA_ACK, ST_ST_DATA_ACK: begin
                     if (status_code == ST_ST_SLA_ACK) begin
                        mode_in = MODE_TX;
                     end
                     err_in       = ERR_OK;
                     err_st_in    = 8'd0;
                     rsp.tx_valid = 1'b1;
                     if (tx_in_range) begin
                        rsp.tx_byte = head_byte;
                        tx_pos_in   = tx_pos_ff + POS_W'(1);
                     end else begin
                        // past the buffer: idle bus level
                        rsp.tx_byte = 8'hFF;
                     end
                     rsp.bus_ctrl = CTRL_ACK;
                  end
                  ST_ST_DATA_NAK: begin
                     // NAK before all bytes went out is an error
                     if (tx_pos_ff >= tx_len_ff) begin
                        err_in    = ERR_OK;
                        err_st_in = 8'd0;
                     end else begin
                        err_in    = ERR_BUS;
                        err_st_in = status_code;
                     end
                     mode_in      = MODE_READY;
                     rsp.bus_ctrl = CTRL_ENABLE;
                  end
                  ST_SR_SLA_ACK, ST_SR_GC_ACK: begin
                     mode_in      = MODE_RX;
                     rsp.bus_ctrl = CTRL_ACK;
                  end
                  ST_SR_DATA_ACK, ST_SR_GC_DATA_ACK: begin
                     // beyond the limit: acked but dropped
                     if (rx_in_range) begin
                        rsp.rx_valid = 1'b1;
                        rsp.rx_index = rx_pos_ff[IDX_W-1:0];
                        rsp.rx_byte  = data_byte;
                        rx_pos_in    = rx_pos_ff + POS_W'(1);
                     end
                     err_in       = ERR_RXING;
                     err_st_in    = 8'd0;
                     rsp.bus_ctrl = CTRL_ACK;
                  end
                  ST_SR_STOP: begin
                     mode_in      = MODE_READY;
                     rsp.bus_ctrl = CTRL_ENABLE;
                  end
                  ST_ST_LAST_ACK, ST_SR_DATA_NAK, ST_SR_GC_DATA_NAK, ST_BUS_ERROR: begin
                     err_in       = ERR_BUS;
                     err_st_in    = status_code;
                     mode_in      = MODE_READY;
                     rsp.bus_ctrl = CTRL_RELEASE;
                  end
                  ST_ARB_SLA_W, ST_ARB_GC, ST_ARB_SLA_R: begin
                     err_in       = ERR_BUS;
                     err_st_in    = status_code;
                     mode_in      = MODE_READY;
                     rsp.bus_ctrl = CTRL_ENABLE;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      // status fields show the state after the word
      rsp.ready_res    = (mode_in == MODE_READY);
      rsp.success      = (err_in == ERR_OK);
      rsp.mode         = mode_in;
      rsp.error_kind   = err_in;
      rsp.error_status = err_st_in;
      rsp.rx_count     = rx_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_READY;
         err_ff    <= ERR_OK;
         err_st_ff <= 8'd0;
         tx_pos_ff <= '0;
         tx_len_ff <= '0;
         rx_pos_ff <= '0;
         rx_lim_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         err_ff    <= err_in;
         err_st_ff <= err_st_in;
         tx_pos_ff <= tx_pos_in;
         tx_len_ff <= tx_len_in;
         rx_pos_ff <= rx_pos_in;
         rx_lim_ff <= rx_lim_in;
      end
   end

   i2cste_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {3'd0,
                       rsp_out.rx_count,
                       rsp_out.rx_byte,
                       rsp_out.rx_index,
                       rsp_out.rx_valid,
                       rsp_out.tx_byte,
                       rsp_out.tx_valid,
                       rsp_out.bus_ctrl,
                       rsp_out.error_status,
                       rsp_out.error_kind,
                       rsp_out.mode,
                       rsp_out.success,
                       rsp_out.ready_res};

endmodule

>>> tb/sv/i2c_slave_transfer_engine_tb.sv
// ----------------------------------------------------------------------------
// i2c_slave_transfer_engine_tb : self-checking bench for the I2C slave engine
// Drives host load/arm words and TWI slave status events into the request
// stream, predicts every result word from a behavioural copy of the engine,
// and checks the result stream field by field under random back-pressure.
// ----------------------------------------------------------------------------
module i2c_slave_transfer_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cste_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int TARGET_WORDS = 730;   // directed plus about 700 random words
   localparam int CALM_FROM    = 620;   // no idling on either side beyond this
   localparam int TAIL_CYCLES  = 8;

   // Behavioural copy of the engine plus the queue of result words still due.
   class engine_scoreboard;
      mode_type    mode_now     = MODE_READY;
      err_type     err_now      = ERR_OK;
      logic [7:0]  err_code_now = 8'h00;
      logic [7:0]  tx_bytes [TX_DEPTH];
      bit          tx_loaded [TX_DEPTH];
      int unsigned tx_ptr       = 0;
      int unsigned tx_len_now   = 0;
      int unsigned rx_ptr       = 0;
      int unsigned rx_limit_now = 0;
      rsp_type     pending_results [$];
      int          errors       = 0;

      // true when the next send would read a store entry never loaded
      function bit next_send_unloaded();
         return tx_ptr < TX_DEPTH && !tx_loaded[tx_ptr];
      endfunction

      function void set_bus_fault(logic [7:0] code);
         err_now      = ERR_BUS;
         err_code_now = code;
      endfunction

      function void note_request(action_type act, logic [4:0] idx, logic [7:0] data,
                                 logic [5:0] len, logic [7:0] code);
         rsp_type     r;
         int unsigned cap;
         r = '0;
         r.bus_ctrl = CTRL_NONE;
         case (act)
            ACT_LOAD: begin
               tx_bytes[idx]  = data;
               tx_loaded[idx] = 1'b1;
            end
            ACT_ARM_TX, ACT_ARM_RX: begin
               cap = (act == ACT_ARM_TX) ? TX_DEPTH : RX_MAX;
               if (mode_now != MODE_READY || len > cap) begin
                  err_now      = ERR_REFUSED;
                  err_code_now = 8'h00;
               end else begin
                  mode_now = MODE_INIT;
                  if (act == ACT_ARM_TX) begin
                     tx_len_now = len;
                     tx_ptr     = 0;
                  end else begin
                     rx_limit_now = len;
                     rx_ptr       = 0;
                  end
                  r.bus_ctrl = CTRL_ACK;
               end
            end
            default: begin
               case (code)
                  ST_ST_SLA_ACK, ST_ST_DATA_ACK: begin
                     if (code == ST_ST_SLA_ACK) mode_now = MODE_TX;
                     err_now      = ERR_OK;
                     err_code_now = 8'h00;
                     r.tx_valid   = 1'b1;
                     if (tx_ptr < TX_DEPTH) begin
                        r.tx_byte = tx_bytes[tx_ptr];
                        tx_ptr++;
                     end else begin
                        r.tx_byte = 8'hFF;   // sending past the buffer
                     end
                     r.bus_ctrl = CTRL_ACK;
                  end
                  ST_ST_DATA_NAK: begin
                     if (tx_ptr >= tx_len_now) begin
                        err_now      = ERR_OK;
                        err_code_now = 8'h00;
                     end else begin
                        set_bus_fault(code);   // master gave up early
                     end
                     mode_now   = MODE_READY;
                     r.bus_ctrl = CTRL_ENABLE;
                  end
                  ST_SR_SLA_ACK, ST_SR_GC_ACK: begin
                     mode_now   = MODE_RX;
                     r.bus_ctrl = CTRL_ACK;
                  end
                  ST_SR_DATA_ACK, ST_SR_GC_DATA_ACK: begin
                     if (rx_ptr < rx_limit_now && rx_ptr < RX_MAX) begin
                        r.rx_valid = 1'b1;
                        r.rx_index = 5'(rx_ptr);
                        r.rx_byte  = data;
                        rx_ptr++;
                     end
                     err_now      = ERR_RXING;
                     err_code_now = 8'h00;
                     r.bus_ctrl   = CTRL_ACK;
                  end
                  ST_SR_STOP: begin
                     mode_now   = MODE_READY;
                     r.bus_ctrl = CTRL_ENABLE;
                  end
                  ST_ST_LAST_ACK, ST_SR_DATA_NAK, ST_SR_GC_DATA_NAK, ST_BUS_ERROR: begin
                     set_bus_fault(code);
                     mode_now   = MODE_READY;
                     r.bus_ctrl = CTRL_RELEASE;
                  end
                  ST_ARB_SLA_W, ST_ARB_GC, ST_ARB_SLA_R: begin
                     set_bus_fault(code);
                     mode_now   = MODE_READY;
                     r.bus_ctrl = CTRL_ENABLE;
                  end
                  default: ;
               endcase
            end
         endcase
         r.ready_res    = (mode_now == MODE_READY);
         r.success      = (err_now == ERR_OK);
         r.mode         = mode_now;
         r.error_kind   = err_now;
         r.error_status = err_code_now;
         r.rx_count     = 6'(rx_ptr);
         pending_results.push_back(r);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [47:0] word);
         rsp_type want;
         rsp_type got;
         if (pending_results.size() == 0) begin
            $error("result word %h arrived with nothing expected", word);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         got  = word[44:0];
         check_field("ready_res",    want.ready_res,    got.ready_res);
         check_field("success",      want.success,      got.success);
         check_field("mode",         want.mode,         got.mode);
         check_field("error_kind",   want.error_kind,   got.error_kind);
         check_field("error_status", want.error_status, got.error_status);
         check_field("bus_ctrl",     want.bus_ctrl,     got.bus_ctrl);
         check_field("tx_valid",     want.tx_valid,     got.tx_valid);
         check_field("tx_byte",      want.tx_byte,      got.tx_byte);
         check_field("rx_valid",     want.rx_valid,     got.rx_valid);
         check_field("rx_index",     want.rx_index,     got.rx_index);
         check_field("rx_byte",      want.rx_byte,      got.rx_byte);
         check_field("rx_count",     want.rx_count,     got.rx_count);
         check_field("zero_fill",    8'h00,             word[47:45]);
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // buf_index, data_byte, length, status_code from bit 0
   logic [1:0]  req_tuser   = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;          // result fields, ready_res at bit 0

   engine_scoreboard sb = new();

   int words_sent  = 0;
   int cycle_count = 0;
   bit req_calm    = 1'b0;   // sender never idles while set
   bit rsp_calm    = 1'b0;   // receiver never stalls while set

   i2c_slave_transfer_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("** i2c_slave_transfer_engine: FAILED **");
            $finish;
         end
      end
   end

   // Result side: check each accepted word, then pick tready for the next edge.
   // Stalls come in random bursts.
   initial begin : result_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!rsp_calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One word onto the request stream, with an optional idle burst first.
   // tready is sampled at the edge, so the word counts once both were high.
   task automatic drive_word(action_type act, logic [4:0] idx, logic [7:0] data,
                             logic [5:0] len, logic [7:0] code);
      int gap;
      if (!req_calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, code, len, data, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, idx, data, len, code);
      words_sent++;
   endtask

   // Sends never touch an unloaded store entry: load it just before.
   task automatic send_request(action_type act, logic [4:0] idx, logic [7:0] data,
                               logic [5:0] len, logic [7:0] code);
      if (act == ACT_EVENT && (code == ST_ST_SLA_ACK || code == ST_ST_DATA_ACK)
          && sb.next_send_unloaded())
         drive_word(ACT_LOAD, 5'(sb.tx_ptr), 8'($urandom), 6'($urandom), 8'($urandom));
      drive_word(act, idx, data, len, code);
   endtask

   // Unused fields carry random junk so every bit of them moves.
   task automatic send_event(logic [7:0] code, logic [7:0] data);
      send_request(ACT_EVENT, 5'($urandom), data, 6'($urandom), code);
   endtask

   task automatic send_arm(action_type act, logic [5:0] len);
      send_request(act, 5'($urandom), 8'($urandom), len, 8'($urandom));
   endtask

   task automatic send_load(logic [4:0] idx, logic [7:0] data);
      send_request(ACT_LOAD, idx, data, 6'($urandom), 8'($urandom));
   endtask

   // Sender holds off until every outstanding result has been seen.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] any_code();
      case ($urandom_range(0, 17))
         0:  return ST_ST_SLA_ACK;
         1:  return ST_ST_DATA_ACK;
         2:  return ST_ST_DATA_NAK;
         3:  return ST_ST_LAST_ACK;
         4:  return ST_SR_SLA_ACK;
         5:  return ST_SR_GC_ACK;
         6:  return ST_SR_DATA_ACK;
         7:  return ST_SR_GC_DATA_ACK;
         8:  return ST_SR_DATA_NAK;
         9:  return ST_SR_GC_DATA_NAK;
         10: return ST_SR_STOP;
         11: return ST_BUS_ERROR;
         12: return ST_ARB_SLA_W;
         13: return ST_ARB_GC;
         14: return ST_ARB_SLA_R;
         default: return 8'($urandom);
      endcase
   endfunction

   // Pick an arm length: mostly short, now and then full size or refused.
   function automatic logic [5:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return 6'($urandom_range(TX_DEPTH + 1, 63));
         1, 2:    return 6'($urandom_range(0, TX_DEPTH));
         default: return 6'($urandom_range(0, 6));
      endcase
   endfunction

   // Slave-transmitter transaction: loads, arm, SLA+R, data sends, an ending.
   task automatic run_transmit();
      int n;
      int sends;
      logic [5:0] len;
      if (sb.mode_now != MODE_READY) send_event(ST_SR_STOP, 8'($urandom));
      n = $urandom_range(0, 4);
      repeat (n) send_load(5'($urandom), 8'($urandom));
      len = pick_length();
      send_arm(ACT_ARM_TX, len);
      send_event(ST_ST_SLA_ACK, 8'($urandom));
      if ($urandom_range(0, 4) == 0) sends = $urandom_range(TX_DEPTH - 2, TX_DEPTH + 4);
      else sends = $urandom_range(0, len + 2);
      repeat (sends) send_event(ST_ST_DATA_ACK, 8'($urandom));
      case ($urandom_range(0, 7))
         0:       send_event(ST_ST_LAST_ACK, 8'($urandom));
         1:       send_event(ST_SR_STOP, 8'($urandom));
         2:       send_event(ST_ARB_SLA_R, 8'($urandom));
         3:       send_event(ST_BUS_ERROR, 8'($urandom));
         default: send_event(ST_ST_DATA_NAK, 8'($urandom));
      endcase
   endtask

   // Slave-receiver transaction: arm, SLA+W or general call, data, an ending.
   task automatic run_receive();
      int n;
      bit general;
      logic [5:0] limit;
      if (sb.mode_now != MODE_READY) send_event(ST_SR_STOP, 8'($urandom));
      limit   = pick_length();
      general = $urandom_range(0, 1);
      send_arm(ACT_ARM_RX, limit);
      send_event(general ? ST_SR_GC_ACK : ST_SR_SLA_ACK, 8'($urandom));
      n = $urandom_range(0, (limit > RX_MAX ? 4 : limit + 3));
      repeat (n) send_event(general ? ST_SR_GC_DATA_ACK : ST_SR_DATA_ACK, 8'($urandom));
      case ($urandom_range(0, 7))
         0:       send_event(general ? ST_SR_GC_DATA_NAK : ST_SR_DATA_NAK, 8'($urandom));
         1:       send_event(general ? ST_ARB_GC : ST_ARB_SLA_W, 8'($urandom));
         2:       send_event(ST_BUS_ERROR, 8'($urandom));
         default: send_event(ST_SR_STOP, 8'($urandom));
      endcase
   endtask

   // Noise: any action, any code, arms at any time.
   task automatic run_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n)
         send_request(action_type'($urandom_range(0, 3)), 5'($urandom), 8'($urandom),
                      6'($urandom), any_code());
   endtask

   initial begin : stimulus
      int next_drain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: store ends, refusals, both directions, every status class
      send_load(5'd0, 8'h00);
      send_load(5'd31, 8'hFF);
      send_load(5'd1, 8'hA5);
      send_arm(ACT_ARM_TX, 6'd33);             // too long
      send_arm(ACT_ARM_RX, 6'd63);             // too long
      send_arm(ACT_ARM_TX, 6'd32);             // largest accepted
      send_arm(ACT_ARM_RX, 6'd0);              // busy, refused
      send_event(ST_ST_SLA_ACK, 8'h00);
      send_event(ST_ST_DATA_ACK, 8'hFF);
      send_event(ST_ST_DATA_NAK, 8'h00);       // NAK before the length was sent
      send_arm(ACT_ARM_TX, 6'd0);
      send_event(ST_ST_SLA_ACK, 8'h5A);
      send_event(ST_ST_DATA_NAK, 8'h5A);       // clean end
      send_arm(ACT_ARM_RX, 6'd1);
      send_event(ST_SR_SLA_ACK, 8'h00);
      send_event(ST_SR_DATA_ACK, 8'h3C);
      send_event(ST_SR_GC_DATA_ACK, 8'hFF);    // beyond the limit, dropped
      send_event(ST_SR_STOP, 8'h00);
      send_arm(ACT_ARM_RX, 6'd32);
      send_event(ST_SR_GC_ACK, 8'h00);
      send_event(ST_SR_GC_DATA_NAK, 8'h00);
      send_event(ST_SR_DATA_NAK, 8'h00);
      send_event(ST_BUS_ERROR, 8'h00);
      send_event(ST_ARB_SLA_W, 8'h00);
      send_event(ST_ARB_GC, 8'h00);
      send_event(ST_ARB_SLA_R, 8'h00);
      send_event(ST_ST_LAST_ACK, 8'h00);
      send_event(8'hF8, 8'h00);                // no-info code
      send_event(8'h55, 8'hFF);                // unknown code
      drain_results();

      next_drain = words_sent + 170;
      while (words_sent < TARGET_WORDS) begin
         if (words_sent >= CALM_FROM) begin
            req_calm = 1'b1;
            rsp_calm = 1'b1;
         end else begin
            req_calm = ($urandom_range(0, 4) == 0);
            rsp_calm = ($urandom_range(0, 4) == 0);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: run_transmit();
            4, 5, 6, 7: run_receive();
            default:    run_noise();
         endcase
         if (words_sent >= next_drain) begin
            drain_results();
            next_drain = words_sent + 170;
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** i2c_slave_transfer_engine: PASSED **");
      end else begin
         $display("** i2c_slave_transfer_engine: FAILED **");
      end
      $finish;
   end

endmodule
